[rtl/ast_pkg.sv]
// ----------------------------------------------------------------------------
// ast_pkg: shared types and constants of the alarm slot table
// Command codes, field widths, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ast_pkg;

    // Field widths of the input and result items.
    localparam int CMD_W  = 3;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int SIDX_W = 4;

    // Command codes; codes five to seven do nothing.
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STORE      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EMPTY_SCAN,
        ST_TICK_SCAN,
        ST_TICK_DRAIN,
        ST_RESULT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_clear;
        logic scan_step;
        logic tick_issue;
        logic read_issue;
        logic store_write;
        logic store_at_scan;
        logic del_clear;
        logic set_next_empty;
        logic clear_all;
        logic fire;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             ignored;
        logic             sec_zero;
        logic             idx_in_range;
        logic             scan_last;
        logic             scan_empty;
        logic             match_hit;
        logic             out_free;
    } dp_status_t;

endpackage

[rtl/ast_in_if.sv]
// ----------------------------------------------------------------------------
// ast_in_if: command channel of the alarm slot table
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface ast_in_if import ast_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [HOUR_W-1:0] hour_value;
    logic [MIN_W-1:0]  minute_value;
    logic [SEC_W-1:0]  second_value;
    logic [SIDX_W-1:0] slot_index;

    modport source (
        output valid, cmd, hour_value, minute_value, second_value, slot_index,
        input  ready
    );
    modport sink (
        input  valid, cmd, hour_value, minute_value, second_value, slot_index,
        output ready
    );
endinterface

[rtl/ast_out_if.sv]
// ----------------------------------------------------------------------------
// ast_out_if: result channel of the alarm slot table
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface ast_out_if import ast_pkg::*;;
    logic              valid;
    logic              ready;
    logic              status;
    logic [SIDX_W-1:0] slot_used;
    logic              alarm_fired;
    logic              ringing;
    logic              entry_valid;
    logic [HOUR_W-1:0] entry_hour;
    logic [MIN_W-1:0]  entry_minute;

    modport source (
        output valid, status, slot_used, alarm_fired, ringing,
               entry_valid, entry_hour, entry_minute,
        input  ready
    );
    modport sink (
        input  valid, status, slot_used, alarm_fired, ringing,
               entry_valid, entry_hour, entry_minute,
        output ready
    );
endinterface

[rtl/ast_ctrl.sv]
// ----------------------------------------------------------------------------
// ast_ctrl: controller of the alarm slot table
// Sequences one item at a time: capture, dispatch, slot scans and the
// hand-off of the result into the output register.
// ----------------------------------------------------------------------------
module ast_ctrl import ast_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status_i,
    output dp_cmd_t    cmd_o
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status_i.ignored)
                begin
                    state_next = ST_RESULT;
                end
                else if (status_i.cmd == CMD_TICK)
                begin
                    state_next = status_i.sec_zero ? ST_TICK_SCAN : ST_RESULT;
                end
                else if (status_i.cmd == CMD_STORE)
                begin
                    state_next = ST_EMPTY_SCAN;
                end
                else if (status_i.cmd == CMD_DELETE)
                begin
                    state_next = status_i.idx_in_range ? ST_EMPTY_SCAN : ST_RESULT;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_EMPTY_SCAN:
            begin
                if (status_i.scan_empty || status_i.scan_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_TICK_SCAN:
            begin
                if (status_i.match_hit)
                begin
                    state_next = ST_RESULT;
                end
                else if (status_i.scan_last)
                begin
                    state_next = ST_TICK_DRAIN;
                end
            end
            ST_TICK_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status_i.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        in_ready = 1'b0;
        cmd_o    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd_o.capture = in_valid;
            end
            ST_DISPATCH:
            begin
                if (!status_i.ignored)
                begin
                    if (status_i.cmd == CMD_TICK || status_i.cmd == CMD_STORE)
                    begin
                        cmd_o.scan_clear = 1'b1;
                    end
                    else if (status_i.cmd == CMD_DELETE)
                    begin
                        cmd_o.scan_clear = 1'b1;
                        cmd_o.del_clear  = status_i.idx_in_range;
                    end
                    else if (status_i.cmd == CMD_DELETE_ALL)
                    begin
                        cmd_o.clear_all = 1'b1;
                    end
                    else if (status_i.cmd == CMD_READ)
                    begin
                        cmd_o.read_issue = 1'b1;
                    end
                end
            end
            ST_EMPTY_SCAN:
            begin
                // The lowest empty slot takes a store or becomes the pointer.
                if (status_i.scan_empty)
                begin
                    if (status_i.cmd == CMD_STORE)
                    begin
                        cmd_o.store_write   = 1'b1;
                        cmd_o.store_at_scan = 1'b1;
                    end
                    else
                    begin
                        cmd_o.set_next_empty = 1'b1;
                    end
                end
                else if (status_i.scan_last)
                begin
                    cmd_o.store_write = (status_i.cmd == CMD_STORE);
                end
                else
                begin
                    cmd_o.scan_step = 1'b1;
                end
            end
            ST_TICK_SCAN:
            begin
                // One slot is read per cycle and compared in the next one.
                if (status_i.match_hit)
                begin
                    cmd_o.fire = 1'b1;
                end
                else
                begin
                    cmd_o.tick_issue = 1'b1;
                    cmd_o.scan_step  = !status_i.scan_last;
                end
            end
            ST_TICK_DRAIN:
            begin
                cmd_o.fire = status_i.match_hit;
            end
            ST_RESULT:
            begin
                cmd_o.load_out = status_i.out_free;
            end
            default:
            begin
                cmd_o = '0;
            end
        endcase
    end

endmodule

[rtl/ast_dp.sv]
// ----------------------------------------------------------------------------
// ast_dp: datapath of the alarm slot table
// Holds the captured item, the slot valid bits, the hour and minute
// memory, the next-slot pointer, the ringing latch, the scan counter and
// the output register.
// ----------------------------------------------------------------------------
module ast_dp import ast_pkg::*;
#(
    parameter  int NUM_SLOTS = 16,
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CMD_W-1:0]  in_cmd,
    input  logic [HOUR_W-1:0] in_hour,
    input  logic [MIN_W-1:0]  in_minute,
    input  logic [SEC_W-1:0]  in_second,
    input  logic [SIDX_W-1:0] in_slot_index,
    input  dp_cmd_t           cmd_i,
    output dp_status_t        status_o,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_status,
    output logic [SIDX_W-1:0] out_slot_used,
    output logic              out_alarm_fired,
    output logic              out_ringing,
    output logic              out_entry_valid,
    output logic [HOUR_W-1:0] out_entry_hour,
    output logic [MIN_W-1:0]  out_entry_minute
);

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_SLOTS - 1);

    // Captured item.
    logic [CMD_W-1:0]  cmd_reg;
    logic [HOUR_W-1:0] hour_reg;
    logic [MIN_W-1:0]  min_reg;
    logic [SEC_W-1:0]  sec_reg;
    logic [SIDX_W-1:0] idx_reg;
    logic              ign_reg;

    // Table state.
    logic              slot_valid_reg [NUM_SLOTS];
    logic [HOUR_W-1:0] slot_hour_mem  [NUM_SLOTS];
    logic [MIN_W-1:0]  slot_min_mem   [NUM_SLOTS];
    logic [IDX_W-1:0]  next_slot_reg;
    logic              ring_latch_reg;

    // Scan and read pipeline.
    logic [IDX_W-1:0]  scan_cnt_reg;
    logic              cmp_live_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [HOUR_W-1:0] rd_hour_reg;
    logic [MIN_W-1:0]  rd_min_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  used_reg;

    // Output register.
    logic              out_valid_reg;
    logic              out_status_reg;
    logic [SIDX_W-1:0] out_slot_used_reg;
    logic              out_alarm_fired_reg;
    logic              out_ringing_reg;
    logic              out_entry_valid_reg;
    logic [HOUR_W-1:0] out_entry_hour_reg;
    logic [MIN_W-1:0]  out_entry_minute_reg;

    logic              out_status_next;
    logic [SIDX_W-1:0] out_slot_used_next;
    logic              out_alarm_fired_next;
    logic              out_ringing_next;
    logic              out_entry_valid_next;
    logic [HOUR_W-1:0] out_entry_hour_next;
    logic [MIN_W-1:0]  out_entry_minute_next;

    logic [IDX_W-1:0]  idx_slot;
    logic              idx_in_range;
    logic [IDX_W-1:0]  store_slot;
    logic [IDX_W-1:0]  store_slot_inc;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              match_hit;
    logic              read_valid;
    logic              out_free;

    // Slot addressed by delete and read.
    assign idx_slot     = IDX_W'(idx_reg);
    assign idx_in_range = (32'(idx_reg) < 32'(NUM_SLOTS));

    // A store goes to the scanned empty slot or to the pointer slot.
    assign store_slot     = cmd_i.store_at_scan ? scan_cnt_reg : next_slot_reg;
    assign store_slot_inc = (store_slot == LAST_SLOT) ? '0 : store_slot + 1'b1;

    assign rd_en   = cmd_i.tick_issue || cmd_i.read_issue;
    assign rd_addr = cmd_i.read_issue ? idx_slot : scan_cnt_reg;

    // Compare of the slot read in the previous cycle.
    assign match_hit = cmp_live_reg && slot_valid_reg[cmp_idx_reg]
                       && (rd_hour_reg == hour_reg) && (rd_min_reg == min_reg);

    assign read_valid = idx_in_range && slot_valid_reg[idx_slot];
    assign out_free   = !out_valid_reg || out_ready;

    // Status toward the controller.
    always_comb
    begin
        status_o.cmd          = cmd_reg;
        status_o.ignored      = ign_reg;
        status_o.sec_zero     = (sec_reg == '0);
        status_o.idx_in_range = idx_in_range;
        status_o.scan_last    = (scan_cnt_reg == LAST_SLOT);
        status_o.scan_empty   = !slot_valid_reg[scan_cnt_reg];
        status_o.match_hit    = match_hit;
        status_o.out_free     = out_free;
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd_i.capture)
        begin
            cmd_reg  <= in_cmd;
            hour_reg <= in_hour;
            min_reg  <= in_minute;
            sec_reg  <= in_second;
            idx_reg  <= in_slot_index;
        end
    end

    // Hour and minute memory with registered read.
    always_ff @(posedge clk)
    begin
        if (cmd_i.store_write)
        begin
            slot_hour_mem[store_slot] <= hour_reg;
            slot_min_mem[store_slot]  <= min_reg;
        end
        if (rd_en)
        begin
            rd_hour_reg <= slot_hour_mem[rd_addr];
            rd_min_reg  <= slot_min_mem[rd_addr];
        end
    end

    // Valid bits, pointer and ringing latch.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
            next_slot_reg  <= '0;
            ring_latch_reg <= 1'b0;
            ign_reg        <= 1'b0;
        end
        else
        begin
            if (cmd_i.capture)
            begin
                ign_reg <= ring_latch_reg;
            end
            if (cmd_i.clear_all)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    slot_valid_reg[i] <= 1'b0;
                end
                next_slot_reg <= '0;
            end
            if (cmd_i.del_clear)
            begin
                slot_valid_reg[idx_slot] <= 1'b0;
            end
            if (cmd_i.store_write)
            begin
                slot_valid_reg[store_slot] <= 1'b1;
                next_slot_reg              <= store_slot_inc;
            end
            if (cmd_i.set_next_empty)
            begin
                next_slot_reg <= scan_cnt_reg;
            end
            if (cmd_i.fire)
            begin
                ring_latch_reg <= 1'b1;
            end
        end
    end

    // Scan counter and compare pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            cmp_live_reg <= 1'b0;
        end
        else
        begin
            cmp_live_reg <= cmd_i.tick_issue;
            if (cmd_i.scan_clear)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd_i.scan_step)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.tick_issue)
        begin
            cmp_idx_reg <= scan_cnt_reg;
        end
    end

    // Slot reported by a store or a match.
    always_ff @(posedge clk)
    begin
        if (cmd_i.capture)
        begin
            hit_reg  <= 1'b0;
            used_reg <= '0;
        end
        else if (cmd_i.fire)
        begin
            hit_reg  <= 1'b1;
            used_reg <= cmp_idx_reg;
        end
        else if (cmd_i.store_write)
        begin
            used_reg <= store_slot;
        end
    end

    // Result fields for the captured command.
    always_comb
    begin
        out_status_next       = 1'b0;
        out_slot_used_next    = '0;
        out_alarm_fired_next  = 1'b0;
        out_ringing_next      = ring_latch_reg;
        out_entry_valid_next  = 1'b0;
        out_entry_hour_next   = '0;
        out_entry_minute_next = '0;
        if (ign_reg)
        begin
            out_status_next  = 1'b1;
            out_ringing_next = 1'b1;
        end
        else
        begin
            case (cmd_reg)
                CMD_TICK:
                begin
                    out_alarm_fired_next = hit_reg;
                    out_slot_used_next   = hit_reg ? SIDX_W'(used_reg) : '0;
                end
                CMD_STORE:
                begin
                    out_slot_used_next = SIDX_W'(used_reg);
                end
                CMD_DELETE:
                begin
                    out_slot_used_next = idx_reg;
                end
                CMD_READ:
                begin
                    out_slot_used_next    = idx_reg;
                    out_entry_valid_next  = read_valid;
                    out_entry_hour_next   = read_valid ? rd_hour_reg : '0;
                    out_entry_minute_next = read_valid ? rd_min_reg : '0;
                end
                default:
                begin
                    out_slot_used_next = '0;
                end
            endcase
        end
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_i.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.load_out)
        begin
            out_status_reg       <= out_status_next;
            out_slot_used_reg    <= out_slot_used_next;
            out_alarm_fired_reg  <= out_alarm_fired_next;
            out_ringing_reg      <= out_ringing_next;
            out_entry_valid_reg  <= out_entry_valid_next;
            out_entry_hour_reg   <= out_entry_hour_next;
            out_entry_minute_reg <= out_entry_minute_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_slot_used    = out_slot_used_reg;
    assign out_alarm_fired  = out_alarm_fired_reg;
    assign out_ringing      = out_ringing_reg;
    assign out_entry_valid  = out_entry_valid_reg;
    assign out_entry_hour   = out_entry_hour_reg;
    assign out_entry_minute = out_entry_minute_reg;

    // Once ringing, the latch holds until reset.
    a_ring_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ring_latch_reg |=> ring_latch_reg)
        else $error("ringing latch dropped without reset");

    // A store leaves its slot marked valid.
    a_store_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_i.store_write |=> slot_valid_reg[$past(store_slot)])
        else $error("stored slot not valid");

    // A result is never loaded over one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_i.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    // An ignored command always reports the ringing state.
    a_ignored_ringing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg) |-> out_ringing_reg)
        else $error("ignored command without ringing");

endmodule

[rtl/alarm_slot_table.sv]
// ----------------------------------------------------------------------------
// alarm_slot_table: table of alarm slots with store, delete, read and tick
// Top level: joins the controller and the datapath to the two channels.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on in_ch as valid/ready items; every command gives exactly
// one item on out_ch. The block works on one item at a time. A store, a
// delete with an index in range and a tick with zero seconds step through
// the slots one per cycle; delete-all, read, an ignored or unknown command,
// an out-of-range delete and a tick with nonzero seconds do no scan.
// in_ch.ready rises again in the cycle after the result is loaded into the
// output register, so a new item is taken while that result still waits.
// When out_ch.ready is low the result holds in the output register and the
// next item finishes its work but waits to be loaded. Reset clears all
// valid marks, the next-slot pointer and the ringing state; after an alarm
// fires every command returns status 1 until the next reset.
// ----------------------------------------------------------------------------
module alarm_slot_table import ast_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    ast_in_if.sink    in_ch,
    ast_out_if.source out_ch
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic       in_ready;

    assign in_ch.ready = in_ready;

    // Controller.
    ast_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status_i (dp_status),
        .cmd_o    (dp_cmd)
    );

    // Datapath.
    ast_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_cmd           (in_ch.cmd),
        .in_hour          (in_ch.hour_value),
        .in_minute        (in_ch.minute_value),
        .in_second        (in_ch.second_value),
        .in_slot_index    (in_ch.slot_index),
        .cmd_i            (dp_cmd),
        .status_o         (dp_status),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_status       (out_ch.status),
        .out_slot_used    (out_ch.slot_used),
        .out_alarm_fired  (out_ch.alarm_fired),
        .out_ringing      (out_ch.ringing),
        .out_entry_valid  (out_ch.entry_valid),
        .out_entry_hour   (out_ch.entry_hour),
        .out_entry_minute (out_ch.entry_minute)
    );

endmodule
